### rtl/mcpg_pkg.sv
// ============================================================================
// mcpg_pkg
// Shared types and constants for the midpoint circle point generator.
// ============================================================================
package mcpg_pkg;

    // Widths of radius, coordinates and the signed decision value.
    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = RADIUS_BITS + 1;
    localparam int DEC_BITS    = RADIUS_BITS + 6;

    // Step queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Decision value at the start of a run is DEC_START - 2*r.
    localparam int DEC_START      = 3;
    // Diagonal move: 4*((x+1)-(y-1)) + 10 folds into 4*(x-y) + 18.
    localparam int DEC_DIAG_ADD   = 18;
    // Axial move: 4*(x+1) + 6 folds into 4*x + 10.
    localparam int DEC_AXIAL_ADD  = 10;
    // A diagonal move ends the run when y < x + 2, an axial one when y < x + 1.
    localparam int DIAG_DONE_GAP  = 2;
    localparam int AXIAL_DONE_GAP = 1;

    // Input operation codes.
    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } opcode_t;

    // The eight symmetric points of one step, in output order.
    typedef enum logic [2:0]
    {
        PT_XP_YP = 3'd0,
        PT_XP_YM = 3'd1,
        PT_XM_YP = 3'd2,
        PT_XM_YM = 3'd3,
        PT_YP_XP = 3'd4,
        PT_YP_XM = 3'd5,
        PT_YM_XP = 3'd6,
        PT_YM_XM = 3'd7
    } point_slot_t;

    // One step to be drawn: center offset, current offsets and end-of-run mark.
    typedef struct packed
    {
        logic [RADIUS_BITS-1:0] radius;
        logic [RADIUS_BITS-1:0] off_x;
        logic [RADIUS_BITS-1:0] off_y;
        logic                   done;
    } step_job_t;

endpackage

### rtl/midpoint_circle_point_generator.sv
// ============================================================================
// midpoint_circle_point_generator
// Midpoint circle point generator: start words load a radius, advance words
// produce the eight symmetric points of each step of the circle.
// ============================================================================
//
//   Channel  | Handshake        | Fields
//   ---------+------------------+----------------------------------------------
//   input    | push / full      | opcode, radius
//   result   | empty / pop      | point_x, point_y, last_of_step, circle_done
//
// The front part takes one word per cycle while the four-entry step queue has
// room; a start or idle advance word produces nothing. The back part drains
// one point per cycle while the result port is not stalled, so an active
// advance word yields eight points on the single result port. A stalled
// result port fills the queue and then raises full. Reset clears the run flag,
// the queue and the output valid flag; there is no clearing pass.
//
module midpoint_circle_point_generator
    import mcpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   opcode,
    input  logic [RADIUS_BITS-1:0] radius,
    output logic                   empty,
    input  logic                   pop,
    output logic [COORD_BITS-1:0]  point_x,
    output logic [COORD_BITS-1:0]  point_y,
    output logic                   last_of_step,
    output logic                   circle_done
);

    logic      accept;
    logic      job_push;
    logic      job_pop;
    logic      q_empty;
    step_job_t job_in;
    step_job_t job_head;

    // A word is accepted while the step queue has room.
    assign accept = push && !full;

    mcpg_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .radius   (radius),
        .job_push (job_push),
        .job      (job_in)
    );

    mcpg_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_in),
        .pop     (job_pop),
        .job_out (job_head),
        .full    (full),
        .empty   (q_empty)
    );

    mcpg_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (q_empty),
        .job          (job_head),
        .job_pop      (job_pop),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

### rtl/mcpg_front.sv
// ============================================================================
// mcpg_front
// Accepts words, keeps the circle state and advances it one midpoint step per
// advance word, handing each step to the back part as a job.
// ============================================================================
module mcpg_front
    import mcpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   opcode,
    input  logic [RADIUS_BITS-1:0] radius,
    output logic                   job_push,
    output step_job_t              job
);

    logic                          running_reg, running_next;
    logic [RADIUS_BITS-1:0]        radius_reg, radius_next;
    logic [RADIUS_BITS-1:0]        x_reg, x_next;
    logic [RADIUS_BITS-1:0]        y_reg, y_next;
    logic signed [DEC_BITS-1:0]    dec_reg, dec_next;

    logic signed [DEC_BITS-1:0]    x_s, y_s;
    logic signed [DEC_BITS-1:0]    dec_step;
    logic [RADIUS_BITS-1:0]        y_step;
    logic [COORD_BITS-1:0]         x_wide, y_wide;
    logic                          step_done;
    logic                          is_advance;

    // Midpoint step from the current state.
    always_comb
    begin
        x_s    = signed'(DEC_BITS'(x_reg));
        y_s    = signed'(DEC_BITS'(y_reg));
        x_wide = COORD_BITS'(x_reg);
        y_wide = COORD_BITS'(y_reg);
        if (dec_reg > signed'(DEC_BITS'(0)))
        begin
            y_step    = y_reg - RADIUS_BITS'(1);
            dec_step  = dec_reg + ((x_s - y_s) <<< 2) + signed'(DEC_BITS'(DEC_DIAG_ADD));
            step_done = y_wide < (x_wide + COORD_BITS'(DIAG_DONE_GAP));
        end
        else
        begin
            y_step    = y_reg;
            dec_step  = dec_reg + (x_s <<< 2) + signed'(DEC_BITS'(DEC_AXIAL_ADD));
            step_done = y_wide < (x_wide + COORD_BITS'(AXIAL_DONE_GAP));
        end
    end

    // A job goes out for each advance word while a run is active.
    assign is_advance = (opcode_t'(opcode) == OP_ADVANCE);
    assign job_push   = accept && is_advance && running_reg;
    assign job.radius = radius_reg;
    assign job.off_x  = x_reg;
    assign job.off_y  = y_reg;
    assign job.done   = step_done;

    // Next state on an accepted word.
    always_comb
    begin
        running_next = running_reg;
        radius_next  = radius_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dec_next     = dec_reg;
        if (accept)
        begin
            if (!is_advance)
            begin
                running_next = 1'b1;
                radius_next  = radius;
                x_next       = '0;
                y_next       = radius;
                dec_next     = signed'(DEC_BITS'(DEC_START))
                             - (signed'(DEC_BITS'(radius)) <<< 1);
            end
            else if (running_reg)
            begin
                if (step_done)
                begin
                    running_next = 1'b0;
                end
                else
                begin
                    x_next   = x_reg + RADIUS_BITS'(1);
                    y_next   = y_step;
                    dec_next = dec_step;
                end
            end
        end
    end

    // Run flag is control state; the rest is cleared for a defined start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            radius_reg  <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            dec_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            radius_reg  <= radius_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            dec_reg     <= dec_next;
        end
    end

endmodule

### rtl/mcpg_queue.sv
// ============================================================================
// mcpg_queue
// Short register queue of step jobs between the front and the back part.
// ============================================================================
module mcpg_queue
    import mcpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_job_t job_in,
    input  logic      pop,
    output step_job_t job_out,
    output logic      full,
    output logic      empty
);

    step_job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg, count_next;
    logic                   do_push, do_pop;

    // Status and head of the queue.
    assign full    = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_BITS+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

### rtl/mcpg_back.sv
// ============================================================================
// mcpg_back
// Expands the queue head job into its eight symmetric points through an
// output register, one per cycle while the register is free or being taken.
// ============================================================================
module mcpg_back
    import mcpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_empty,
    input  step_job_t             job,
    output logic                  job_pop,
    output logic [COORD_BITS-1:0] point_x,
    output logic [COORD_BITS-1:0] point_y,
    output logic                  last_of_step,
    output logic                  circle_done,
    output logic                  empty,
    input  logic                  pop
);

    point_slot_t            slot_reg, slot_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]  px_reg, py_reg;
    logic                   last_reg, done_reg;

    logic [COORD_BITS-1:0]  r_w, x_w, y_w;
    logic [COORD_BITS-1:0]  rx_p, rx_m, ry_p, ry_m;
    logic [COORD_BITS-1:0]  px_new, py_new;
    logic                   slot_last;
    logic                   out_free, emit;

    // Coordinates around the center, wrapping at the coordinate width.
    always_comb
    begin
        r_w  = COORD_BITS'(job.radius);
        x_w  = COORD_BITS'(job.off_x);
        y_w  = COORD_BITS'(job.off_y);
        rx_p = r_w + x_w;
        rx_m = r_w - x_w;
        ry_p = r_w + y_w;
        ry_m = r_w - y_w;
    end

    // Point selected by the current slot.
    always_comb
    begin
        unique case (slot_reg)
            PT_XP_YP: begin px_new = rx_p; py_new = ry_p; end
            PT_XP_YM: begin px_new = rx_p; py_new = ry_m; end
            PT_XM_YP: begin px_new = rx_m; py_new = ry_p; end
            PT_XM_YM: begin px_new = rx_m; py_new = ry_m; end
            PT_YP_XP: begin px_new = ry_p; py_new = rx_p; end
            PT_YP_XM: begin px_new = ry_p; py_new = rx_m; end
            PT_YM_XP: begin px_new = ry_m; py_new = rx_p; end
            PT_YM_XM: begin px_new = ry_m; py_new = rx_m; end
            default:  begin px_new = rx_p; py_new = ry_p; end
        endcase
    end

    // Emit when a job waits and the output register is free or being taken.
    assign slot_last = (slot_reg == PT_YM_XM);
    assign out_free  = !out_valid_reg || pop;
    assign emit      = !job_empty && out_free;
    assign job_pop   = emit && slot_last;

    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            slot_next      = point_slot_t'(slot_reg + 3'd1);
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= PT_XP_YP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            px_reg   <= px_new;
            py_reg   <= py_new;
            last_reg <= slot_last;
            done_reg <= slot_last && job.done;
        end
    end

    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;
    assign empty        = !out_valid_reg;

endmodule
